FILE: rtl/ckcv_pkg.sv
// ============================================================================
// ckcv_pkg
// Shared types, constants and the CRC-32 byte step for the cache validator.
// ============================================================================
package ckcv_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int KEY_W         = 32;
    localparam int BYTE_W        = 8;
    localparam int DAY_W         = 32;
    localparam int CRC_W         = 32;
    localparam int AGE_W         = 16;
    localparam int STATUS_W      = 4;
    localparam int ENTRY_COUNT_W = 7;

    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 5;

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd7;

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_RECORD = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID      = 4'd0,
        ST_NO_URL     = 4'd1,
        ST_NOT_CACHED = 4'd2,
        ST_CHANGED    = 4'd3,
        ST_TOO_OLD    = 4'd4,
        ST_UPDATED    = 4'd5,
        ST_INSERTED   = 4'd6,
        ST_FULL       = 4'd7,
        ST_CLEARED    = 4'd8
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CRC_W-1:0] hash;
        logic [DAY_W-1:0] day;
    } entry_t;

    typedef struct packed {
        logic crc_step;
        logic crc_reset;
        logic clear_table;
        logic capture;
        logic emit_clear;
        logic emit_no_url;
        logic read_en;
        logic idx_inc;
        logic finish_hit;
        logic finish_miss;
    } ctrl_cmd_t;

    typedef struct packed {
        logic saw_any;
        logic scan_end;
        logic hit;
        logic out_valid;
    } dp_status_t;

    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/ckcv_datapath.sv
// ============================================================================
// ckcv_datapath
// CRC accumulator, entry memory, scan index, age check and result register.
// ============================================================================
module ckcv_datapath
    import ckcv_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [AGE_W-1:0]    cfg_wdata,
    input  logic [S_DATA_W-1:0] in_data,
    input  logic [S_USER_W-1:0] in_user,
    input  ctrl_cmd_t           ctrl,
    output dp_status_t          stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [M_USER_W-1:0] m_tuser
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [KEY_W-1:0]  in_key;
    logic [BYTE_W-1:0] in_byte;
    logic [DAY_W-1:0]  in_today;
    logic              in_bv;
    logic              in_is_record;

    logic [AGE_W-1:0]  max_age_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic              saw_reg;
    logic [CW-1:0]     used_reg;
    logic [CW-1:0]     used_next;
    logic [CW-1:0]     idx_reg;

    logic [KEY_W-1:0]  key_reg;
    logic [DAY_W-1:0]  today_reg;
    logic [CRC_W-1:0]  crc_fin_reg;
    logic              is_record_reg;
    entry_t            rd_data_reg;

    entry_t            entry_mem [TABLE_ENTRIES];

    logic [CRC_W-1:0]  fold_val;
    logic              saw_any;
    logic              full;
    logic              too_old;
    logic [DAY_W-1:0]  expire_day;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_entry;
    logic              emit;

    logic              res_need;
    status_t           res_status;
    logic [CRC_W-1:0]  res_crc;

    logic                     out_valid_reg;
    logic                     out_need_reg;
    status_t                  out_status_reg;
    logic [CRC_W-1:0]         out_crc_reg;
    logic [ENTRY_COUNT_W-1:0] out_count_reg;

    assign in_key       = in_data[31:0];
    assign in_byte      = in_data[39:32];
    assign in_today     = in_data[71:40];
    assign in_bv        = in_user[2];
    assign in_is_record = (cmd_t'(in_user[1:0]) == CMD_RECORD);

    assign fold_val = in_bv ? crc_fold(crc_reg, in_byte) : crc_reg;
    assign saw_any  = saw_reg | in_bv;
    assign full     = (used_reg == CW'(TABLE_ENTRIES));

    assign expire_day = rd_data_reg.day + {{(DAY_W-AGE_W){1'b0}}, max_age_reg};
    assign too_old    = (today_reg > expire_day);

    assign stat.saw_any   = saw_any;
    assign stat.scan_end  = (idx_reg == used_reg);
    assign stat.hit       = (rd_data_reg.key == key_reg);
    assign stat.out_valid = out_valid_reg;

    assign emit = ctrl.emit_clear | ctrl.emit_no_url | ctrl.finish_hit | ctrl.finish_miss;

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = idx_reg[AW-1:0];
        wr_entry = '{key: key_reg, hash: crc_fin_reg, day: today_reg};
        used_next = used_reg;
        if (ctrl.clear_table)
        begin
            used_next = '0;
        end
        else if (ctrl.finish_hit && is_record_reg)
        begin
            wr_en = 1'b1;
        end
        else if (ctrl.finish_miss && is_record_reg && !full)
        begin
            wr_en     = 1'b1;
            wr_addr   = used_reg[AW-1:0];
            used_next = used_reg + CW'(1);
        end
    end

    always_comb
    begin
        res_need   = 1'b0;
        res_status = ST_VALID;
        res_crc    = crc_fin_reg;
        priority if (ctrl.emit_clear)
        begin
            res_status = ST_CLEARED;
            res_crc    = '0;
        end
        else if (ctrl.emit_no_url)
        begin
            res_status = ST_NO_URL;
            res_crc    = '0;
        end
        else if (ctrl.finish_hit)
        begin
            priority if (is_record_reg)
            begin
                res_status = ST_UPDATED;
            end
            else if (rd_data_reg.hash != crc_fin_reg)
            begin
                res_status = ST_CHANGED;
                res_need   = 1'b1;
            end
            else if (too_old)
            begin
                res_status = ST_TOO_OLD;
                res_need   = 1'b1;
            end
            else
            begin
                res_status = ST_VALID;
            end
        end
        else
        begin
            priority if (!is_record_reg)
            begin
                res_status = ST_NOT_CACHED;
                res_need   = 1'b1;
            end
            else if (full)
            begin
                res_status = ST_FULL;
            end
            else
            begin
                res_status = ST_INSERTED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg   <= MAX_AGE_RESET;
            crc_reg       <= CRC_INIT;
            saw_reg       <= 1'b0;
            used_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_age_reg <= cfg_wdata;
            end
            if (ctrl.crc_reset)
            begin
                crc_reg <= CRC_INIT;
                saw_reg <= 1'b0;
            end
            else if (ctrl.crc_step && in_bv)
            begin
                crc_reg <= fold_val;
                saw_reg <= 1'b1;
            end
            used_reg <= used_next;
            if (ctrl.capture)
            begin
                idx_reg <= '0;
            end
            else if (ctrl.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            key_reg       <= in_key;
            today_reg     <= in_today;
            is_record_reg <= in_is_record;
            crc_fin_reg   <= saw_any ? ~fold_val : '0;
        end
        if (emit)
        begin
            out_need_reg   <= res_need;
            out_status_reg <= res_status;
            out_crc_reg    <= res_crc;
            out_count_reg  <= ENTRY_COUNT_W'(used_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.read_en)
        begin
            rd_data_reg <= entry_mem[idx_reg[AW-1:0]];
        end
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_crc_reg};
    assign m_tuser  = {out_status_reg, out_need_reg};

endmodule

FILE: rtl/ckcv_ctrl.sv
// ============================================================================
// ckcv_ctrl
// Request sequencer: byte folding, command dispatch and the table scan.
// ============================================================================
module ckcv_ctrl
    import ckcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tlast,
    input  logic [1:0] s_cmd,
    input  logic       m_tready,
    input  dp_status_t stat,
    output ctrl_cmd_t  ctrl
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        CHECK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == IDLE) && (!stat.out_valid || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    unique case (s_cmd)
                        CMD_QUERY, CMD_RECORD:
                        begin
                            if (!s_tlast)
                            begin
                                ctrl.crc_step = 1'b1;
                            end
                            else
                            begin
                                ctrl.crc_reset = 1'b1;
                                if (s_cmd == CMD_QUERY && !stat.saw_any)
                                begin
                                    ctrl.emit_no_url = 1'b1;
                                end
                                else
                                begin
                                    ctrl.capture = 1'b1;
                                    state_next   = SCAN;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ctrl.clear_table = 1'b1;
                            ctrl.crc_reset   = 1'b1;
                            ctrl.emit_clear  = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            SCAN:
            begin
                if (stat.scan_end)
                begin
                    ctrl.finish_miss = 1'b1;
                    state_next       = IDLE;
                end
                else
                begin
                    ctrl.read_en = 1'b1;
                    state_next   = CHECK;
                end
            end
            CHECK:
            begin
                if (stat.hit)
                begin
                    ctrl.finish_hit = 1'b1;
                    state_next      = IDLE;
                end
                else
                begin
                    ctrl.idx_inc = 1'b1;
                    state_next   = SCAN;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/crc_keyed_cache_validator.sv
// ============================================================================
// crc_keyed_cache_validator
// CRC-32 keyed cache table: query freshness, record fetches, clear the table.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------------
//   s_axis   | in        | s_axis_tvalid/tready    | tdata, tuser, tlast (url_last)
//   m_axis   | out       | m_axis_tvalid/tready    | tdata, tuser
//   cfg      | in        | cfg_we                  | cfg_wdata (max_age_days)
//
// A request that is not the last of its URL folds its byte, if byte_valid, into the CRC.
// A last request of a query or record starts a table scan that reads the used entries
// one at a time through the registered memory port and ends on the first key hit or,
// on a miss, after the last used entry.
// A clear or a query without URL bytes is answered without a scan. The result waits in an
// output register; the next request is taken once that register is free or drained.
// Reset empties the table count and restarts the CRC; no clearing pass is needed.
// ============================================================================
module crc_keyed_cache_validator
    import ckcv_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [AGE_W-1:0]    cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // app_key[31:0], url_byte[39:32], today[71:40]
    input  logic [S_USER_W-1:0] s_axis_tuser,   // cmd[1:0], byte_valid[2]
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // url_crc[31:0], entry_count[38:32], zero[39]
    output logic [M_USER_W-1:0] m_axis_tuser    // needs_update[0], status[4:1]
);

    ctrl_cmd_t  dp_cmd;
    dp_status_t dp_stat;

    ckcv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tlast  (s_axis_tlast),
        .s_cmd    (s_axis_tuser[1:0]),
        .m_tready (m_axis_tready),
        .stat     (dp_stat),
        .ctrl     (dp_cmd)
    );

    ckcv_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .ctrl      (dp_cmd),
        .stat      (dp_stat),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser)
    );

    a_one_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dp_cmd.capture, dp_cmd.emit_clear, dp_cmd.emit_no_url,
                  dp_cmd.finish_hit, dp_cmd.finish_miss}))
        else $error("more than one result source in a cycle");

    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
        else $error("request taken while a result is stalled");

    a_no_ready_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.read_en |=> !s_axis_tready)
        else $error("request taken during table scan");

    a_out_free_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.capture |=> !m_axis_tvalid)
        else $error("result register busy when scan starts");

endmodule
